// File: rtl/core/tcs_pkg.sv
`default_nettype none

package tcs_pkg;

  localparam int unsigned NumKw = 16;
  localparam int unsigned NumOp = 11;

  // Token length saturates here; no fixed word is this long.
  localparam logic [3:0] CountMax = 4'd8;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharZ     = 8'h7A;

  typedef enum logic [2:0] {
    ClsReserved  = 3'd0,
    ClsOperator  = 3'd1,
    ClsVariable  = 3'd2,
    ClsInteger   = 3'd3,
    ClsFloat     = 3'd4,
    ClsLineBreak = 3'd5,
    ClsError     = 3'd6
  } tok_class_e;

  typedef enum logic [1:0] {
    NumNone  = 2'd0,
    NumInt   = 2'd1,
    NumFloat = 2'd2
  } num_phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } scan_in_t;

  typedef struct packed {
    tok_class_e token_class;
    logic       last;
  } scan_out_t;

  localparam logic [7:0] KwText [NumKw][8] = '{
    '{"c", "o", "n", "s", "t", CharNul, CharNul, CharNul},
    '{"i", "n", "t", CharNul, CharNul, CharNul, CharNul, CharNul},
    '{"f", "l", "o", "a", "t", CharNul, CharNul, CharNul},
    '{"d", "o", "u", "b", "l", "e", CharNul, CharNul},
    '{"l", "o", "n", "g", CharNul, CharNul, CharNul, CharNul},
    '{"s", "t", "a", "t", "i", "c", CharNul, CharNul},
    '{"v", "o", "i", "d", CharNul, CharNul, CharNul, CharNul},
    '{"c", "h", "a", "r", CharNul, CharNul, CharNul, CharNul},
    '{"e", "x", "t", "e", "r", "n", CharNul, CharNul},
    '{"r", "e", "t", "u", "r", "n", CharNul, CharNul},
    '{"b", "r", "e", "a", "k", CharNul, CharNul, CharNul},
    '{"e", "n", "u", "m", CharNul, CharNul, CharNul, CharNul},
    '{"s", "t", "r", "u", "c", "t", CharNul, CharNul},
    '{"t", "y", "p", "e", "d", "e", "f", CharNul},
    '{"u", "n", "i", "o", "n", CharNul, CharNul, CharNul},
    '{"g", "o", "t", "o", CharNul, CharNul, CharNul, CharNul}
  };

  localparam logic [3:0] KwLen [NumKw] = '{
    4'd5, 4'd3, 4'd5, 4'd6, 4'd4, 4'd6, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd5, 4'd4, 4'd6, 4'd7, 4'd5, 4'd4
  };

  localparam logic [7:0] OpText [NumOp][4] = '{
    '{"+", CharNul, CharNul, CharNul},
    '{"-", CharNul, CharNul, CharNul},
    '{"*", CharNul, CharNul, CharNul},
    '{"/", CharNul, CharNul, CharNul},
    '{"=", CharNul, CharNul, CharNul},
    '{"=", "=", CharNul, CharNul},
    '{"!", "=", CharNul, CharNul},
    '{">", "=", CharNul, CharNul},
    '{"<", "=", CharNul, CharNul},
    '{">", CharNul, CharNul, CharNul},
    '{"<", CharNul, CharNul, CharNul}
  };

  localparam logic [3:0] OpLen [NumOp] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
  };

endpackage

`default_nettype wire

// File: rtl/core/token_class_scanner.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ------------------------------------
// in        in         in_valid_i/in_stall_o   in_data_i  (char_code, end_of_stream)
// out       out        out_valid_o/out_stall_i out_data_o (token_class, last)
//
// One character transaction is taken per cycle unless the input stalls. It is
// held in the input register, then the scan state updates and zero, one or two
// results go into a four-entry result queue. A result is visible in the cycle
// after it is written into the queue.
// Sustained rate is one item per cycle unless stalled, bounded by the single
// output port: an item with two results (token plus line break) uses two slots.
// Reset clears the scan state, the queue and the sticky error flag.
// The input stalls only while the input register is full and the queue lacks
// room for two results.

module token_class_scanner (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire tcs_pkg::scan_in_t  in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output tcs_pkg::scan_out_t      out_data_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = PtrW + 1;
  localparam logic [CntW-1:0] QRoom2 = CntW'(QDepth - 2);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic              in_valid_q;
  tcs_pkg::scan_in_t in_data_q;
  logic              advance;
  logic              consume;

  logic [CntW-1:0] q_cnt_q, q_cnt_d;

  // Queue must have room for the worst case of two results before we advance.
  assign advance    = (q_cnt_q <= QRoom2);
  assign in_stall_o = in_valid_q && !advance;
  assign consume    = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------------
  logic [tcs_pkg::NumKw-1:0] kw_live_q, kw_live_d, kw_step;
  logic [tcs_pkg::NumOp-1:0] op_live_q, op_live_d, op_step;
  logic [3:0]                char_cnt_q, char_cnt_d;
  logic                      ident_ok_q, ident_ok_d;
  tcs_pkg::num_phase_e       num_phase_q, num_phase_d;
  logic                      err_stuck_q, err_stuck_d;

  logic [7:0] ch;
  logic       eos;
  logic       is_sep;
  logic       is_digit;
  logic       is_lower;

  assign ch       = in_data_q.char_code;
  assign eos      = in_data_q.end_of_stream;
  assign is_sep   = (ch == tcs_pkg::CharSemi) || (ch == tcs_pkg::CharSpace) ||
                    ((ch >= tcs_pkg::CharTab) && (ch <= tcs_pkg::CharCr));
  assign is_digit = (ch >= tcs_pkg::Char0) && (ch <= tcs_pkg::Char9);
  assign is_lower = (ch >= tcs_pkg::CharA) && (ch <= tcs_pkg::CharZ);

  // Per-word prefix tracking: a word stays live if the next char matches.
  always_comb begin
    for (int k = 0; k < tcs_pkg::NumKw; k++) begin
      kw_step[k] = kw_live_q[k] && (char_cnt_q < tcs_pkg::KwLen[k]) &&
                   (tcs_pkg::KwText[k][char_cnt_q[2:0]] == ch);
    end
    for (int k = 0; k < tcs_pkg::NumOp; k++) begin
      op_step[k] = op_live_q[k] && (char_cnt_q < tcs_pkg::OpLen[k]) &&
                   (tcs_pkg::OpText[k][char_cnt_q[1:0]] == ch);
    end
  end

  // Class of the pending token.
  logic                kw_hit;
  logic                op_hit;
  tcs_pkg::tok_class_e tok_cls;

  always_comb begin
    kw_hit = 1'b0;
    op_hit = 1'b0;
    for (int k = 0; k < tcs_pkg::NumKw; k++) begin
      kw_hit = kw_hit | (kw_live_q[k] && (tcs_pkg::KwLen[k] == char_cnt_q));
    end
    for (int k = 0; k < tcs_pkg::NumOp; k++) begin
      op_hit = op_hit | (op_live_q[k] && (tcs_pkg::OpLen[k] == char_cnt_q));
    end
    priority if (kw_hit) begin
      tok_cls = tcs_pkg::ClsReserved;
    end else if (op_hit) begin
      tok_cls = tcs_pkg::ClsOperator;
    end else if (ident_ok_q) begin
      tok_cls = tcs_pkg::ClsVariable;
    end else if (num_phase_q == tcs_pkg::NumInt) begin
      tok_cls = tcs_pkg::ClsInteger;
    end else if (num_phase_q == tcs_pkg::NumFloat) begin
      tok_cls = tcs_pkg::ClsFloat;
    end else begin
      tok_cls = tcs_pkg::ClsError;
    end
  end

  logic               has_cls;
  logic               has_lb;
  logic [1:0]         push_cnt;
  tcs_pkg::scan_out_t res_a;
  tcs_pkg::scan_out_t res_b;

  always_comb begin
    kw_live_d   = kw_live_q;
    op_live_d   = op_live_q;
    char_cnt_d  = char_cnt_q;
    ident_ok_d  = ident_ok_q;
    num_phase_d = num_phase_q;
    err_stuck_d = err_stuck_q;
    has_cls     = 1'b0;
    has_lb      = 1'b0;

    if (consume && !err_stuck_q) begin
      if (!eos && !is_sep) begin
        kw_live_d = kw_step;
        op_live_d = op_step;
        if (!((is_digit && (char_cnt_q != 4'd0)) || is_lower ||
              (ch == tcs_pkg::CharUnder))) begin
          ident_ok_d = 1'b0;
        end
        if ((num_phase_q != tcs_pkg::NumNone) && !is_digit) begin
          if ((ch == tcs_pkg::CharDot) && (num_phase_q == tcs_pkg::NumInt)) begin
            num_phase_d = tcs_pkg::NumFloat;
          end else begin
            num_phase_d = tcs_pkg::NumNone;
          end
        end
        if (char_cnt_q < tcs_pkg::CountMax) begin
          char_cnt_d = char_cnt_q + 4'd1;
        end
      end else begin
        has_cls = (char_cnt_q != 4'd0);
        if (has_cls && (tok_cls == tcs_pkg::ClsError)) begin
          err_stuck_d = 1'b1;
        end
        // an error suppresses the line break of its ';'
        has_lb = !eos && (ch == tcs_pkg::CharSemi) &&
                 !(has_cls && (tok_cls == tcs_pkg::ClsError));
        kw_live_d   = '1;
        op_live_d   = '1;
        char_cnt_d  = 4'd0;
        ident_ok_d  = 1'b1;
        num_phase_d = tcs_pkg::NumInt;
      end
    end

    res_a.token_class = has_cls ? tok_cls : tcs_pkg::ClsLineBreak;
    res_a.last        = !(has_cls && has_lb);
    res_b.token_class = tcs_pkg::ClsLineBreak;
    res_b.last        = 1'b1;
    push_cnt          = {1'b0, has_cls} + {1'b0, has_lb};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_live_q   <= '1;
      op_live_q   <= '1;
      char_cnt_q  <= 4'd0;
      ident_ok_q  <= 1'b1;
      num_phase_q <= tcs_pkg::NumInt;
      err_stuck_q <= 1'b0;
    end else begin
      kw_live_q   <= kw_live_d;
      op_live_q   <= op_live_d;
      char_cnt_q  <= char_cnt_d;
      ident_ok_q  <= ident_ok_d;
      num_phase_q <= num_phase_d;
      err_stuck_q <= err_stuck_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  tcs_pkg::scan_out_t q_mem [QDepth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic               pop;

  assign wr_ptr_nx   = wr_ptr_q + 1'b1;
  assign out_valid_o = (q_cnt_q != '0);
  assign out_data_o  = q_mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    q_cnt_d  = q_cnt_q + CntW'(push_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != 2'd0) begin
      q_mem[wr_ptr_q] <= res_a;
    end
    if (push_cnt == 2'd2) begin
      q_mem[wr_ptr_nx] <= res_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= CntW'(QDepth))
    else $error("result queue overflow");

  a_error_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.token_class == tcs_pkg::ClsError)) |-> out_data_o.last)
    else $error("compile error result not marked last");

  a_lb_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.token_class == tcs_pkg::ClsLineBreak)) |-> out_data_o.last)
    else $error("line break result not marked last");

  a_stuck_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_stuck_q |=> (err_stuck_q && (push_cnt == 2'd0)))
    else $error("scanner left error state or emitted after error");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RandomItems = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  tcs_pkg::scan_in_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  tcs_pkg::scan_out_t out_data_o;

  token_class_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Scanner model: per-token match masks, length, identifier/number
  // flags, plus the sticky error flag that only reset clears.
  // ------------------------------------------------------------------
  typedef struct {
    logic [tcs_pkg::NumKw-1:0] kw_live;
    logic [tcs_pkg::NumOp-1:0] op_live;
    logic [3:0]                count;
    logic                      ident_ok;
    tcs_pkg::num_phase_e       phase;
    logic                      stuck;
  } scan_state_t;

  // One row of directed stimulus. n < 0: expectation comes from the model,
  // otherwise n results are typed in (c0, then c1), last set on the final one.
  typedef struct {
    logic [7:0]          ch;
    logic                eos;
    int                  n;
    tcs_pkg::tok_class_e c0;
    tcs_pkg::tok_class_e c1;
  } stim_row_t;

  scan_state_t        scan_st;
  tcs_pkg::scan_out_t expected_results [$];
  stim_row_t          opening_rows [$];
  stim_row_t          closing_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned random_items_sent = 0;
  logic        held_once = 1'b0;

  function automatic scan_state_t cleared_token(scan_state_t s);
    scan_state_t n;
    n          = s;
    n.kw_live  = '1;
    n.op_live  = '1;
    n.count    = '0;
    n.ident_ok = 1'b1;
    n.phase    = tcs_pkg::NumInt;
    return n;
  endfunction

  function automatic scan_state_t absorb_char(scan_state_t s, logic [7:0] c);
    scan_state_t n;
    logic        digit;
    n     = s;
    digit = (c >= tcs_pkg::Char0) && (c <= tcs_pkg::Char9);
    // count[2:0] / count[1:0] stay in range: only read while count < length
    for (int k = 0; k < tcs_pkg::NumKw; k++)
      n.kw_live[k] = s.kw_live[k] && (s.count < tcs_pkg::KwLen[k]) &&
                     (tcs_pkg::KwText[k][s.count[2:0]] == c);
    for (int k = 0; k < tcs_pkg::NumOp; k++)
      n.op_live[k] = s.op_live[k] && (s.count < tcs_pkg::OpLen[k]) &&
                     (tcs_pkg::OpText[k][s.count[1:0]] == c);
    if (!((digit && s.count != 0) || (c >= tcs_pkg::CharA && c <= tcs_pkg::CharZ) ||
          c == tcs_pkg::CharUnder))
      n.ident_ok = 1'b0;
    if (s.phase != tcs_pkg::NumNone && !digit)
      n.phase = (c == tcs_pkg::CharDot && s.phase == tcs_pkg::NumInt) ?
                tcs_pkg::NumFloat : tcs_pkg::NumNone;
    if (s.count < tcs_pkg::CountMax)
      n.count = s.count + 4'd1;
    return n;
  endfunction

  // Priority: reserved, operator, variable, integer, float, else error.
  function automatic tcs_pkg::tok_class_e token_class_of(scan_state_t s);
    logic kw_hit;
    logic op_hit;
    kw_hit = 1'b0;
    op_hit = 1'b0;
    for (int k = 0; k < tcs_pkg::NumKw; k++)
      if (s.kw_live[k] && tcs_pkg::KwLen[k] == s.count) kw_hit = 1'b1;
    for (int k = 0; k < tcs_pkg::NumOp; k++)
      if (s.op_live[k] && tcs_pkg::OpLen[k] == s.count) op_hit = 1'b1;
    if (kw_hit)                          return tcs_pkg::ClsReserved;
    if (op_hit)                          return tcs_pkg::ClsOperator;
    if (s.ident_ok)                      return tcs_pkg::ClsVariable;
    if (s.phase == tcs_pkg::NumInt)      return tcs_pkg::ClsInteger;
    if (s.phase == tcs_pkg::NumFloat)    return tcs_pkg::ClsFloat;
    return tcs_pkg::ClsError;
  endfunction

  // Class a word would get as a complete token.
  function automatic tcs_pkg::tok_class_e word_class(string w);
    scan_state_t s;
    s.stuck = 1'b0;
    s = cleared_token(s);
    for (int i = 0; i < w.len(); i++)
      s = absorb_char(s, w[i]);
    return token_class_of(s);
  endfunction

  function automatic logic is_separator(logic [7:0] c);
    return c == tcs_pkg::CharSemi || c == tcs_pkg::CharSpace ||
           (c >= tcs_pkg::CharTab && c <= tcs_pkg::CharCr);
  endfunction

  // Advance the model by one transaction; returns the results it causes.
  task automatic scan_predict(input tcs_pkg::scan_in_t it, output int n,
                              output tcs_pkg::scan_out_t r [2]);
    tcs_pkg::tok_class_e cls;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    if (!scan_st.stuck) begin
      if (!it.end_of_stream && !is_separator(it.char_code)) begin
        scan_st = absorb_char(scan_st, it.char_code);
      end else begin
        if (scan_st.count != 0) begin
          cls = token_class_of(scan_st);
          r[0].token_class = cls;
          n = 1;
          if (cls == tcs_pkg::ClsError) scan_st.stuck = 1'b1;
        end
        scan_st = cleared_token(scan_st);
        // line break suppressed once the error latched
        if (!it.end_of_stream && it.char_code == tcs_pkg::CharSemi && !scan_st.stuck) begin
          r[n].token_class = tcs_pkg::ClsLineBreak;
          n++;
        end
        if (n > 0) r[n-1].last = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // ------------------------------------------------------------------
  // Input side: bursts of back-to-back transactions, random gaps between.
  // Expectations are queued at the edge where the transaction is taken.
  // ------------------------------------------------------------------
  task automatic send_item(tcs_pkg::scan_in_t d, int typed_n,
                           tcs_pkg::tok_class_e c0, tcs_pkg::tok_class_e c1);
    int                 pred_n;
    tcs_pkg::scan_out_t pred [2];
    tcs_pkg::scan_out_t typed [2];
    int unsigned        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    scan_predict(d, pred_n, pred);
    if (typed_n < 0) begin
      for (int i = 0; i < pred_n; i++) expected_results.push_back(pred[i]);
    end else begin
      typed[0].token_class = c0;
      typed[0].last        = (typed_n == 1);
      typed[1].token_class = c1;
      typed[1].last        = 1'b1;
      for (int i = 0; i < typed_n; i++) expected_results.push_back(typed[i]);
    end
  endtask

  task automatic send_rows(ref stim_row_t rows [$]);
    tcs_pkg::scan_in_t d;
    foreach (rows[i]) begin
      d.char_code     = rows[i].ch;
      d.end_of_stream = rows[i].eos;
      send_item(d, rows[i].n, rows[i].c0, rows[i].c1);
    end
  endtask

  task automatic send_char(logic [7:0] c, logic eos);
    tcs_pkg::scan_in_t d;
    d.char_code     = c;
    d.end_of_stream = eos;
    send_item(d, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
  endtask

  task automatic add_row(ref stim_row_t rows [$], input logic [7:0] ch, input logic eos,
                         input int n, input tcs_pkg::tok_class_e c0,
                         input tcs_pkg::tok_class_e c1);
    stim_row_t r;
    r.ch  = ch;
    r.eos = eos;
    r.n   = n;
    r.c0  = c0;
    r.c1  = c1;
    rows.push_back(r);
  endtask

  task automatic add_word_rows(ref stim_row_t rows [$], input string w);
    for (int i = 0; i < w.len(); i++)
      add_row(rows, w[i], 1'b0, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
  endtask

  // ------------------------------------------------------------------
  // Random token builders
  // ------------------------------------------------------------------
  function automatic string rand_from(string set, int unsigned len);
    string w;
    w = "";
    for (int unsigned i = 0; i < len; i++)
      w = $sformatf("%s%c", w, set[$urandom_range(0, set.len() - 1)]);
    return w;
  endfunction

  function automatic string fixed_word(logic [7:0] text [8], logic [3:0] len);
    string w;
    w = "";
    for (int i = 0; i < len; i++) w = $sformatf("%s%c", w, text[i]);
    return w;
  endfunction

  function automatic string random_token();
    string       lower;
    string       tail;
    string       w;
    int unsigned k;
    logic [7:0]  op_text [8];
    lower = "abcdefghijklmnopqrstuvwxyz_";
    tail  = "abcdefghijklmnopqrstuvwxyz_0123456789";
    case ($urandom_range(0, 9))
      0, 1: begin
        k = $urandom_range(0, tcs_pkg::NumKw - 1);
        w = fixed_word(tcs_pkg::KwText[k], tcs_pkg::KwLen[k]);
      end
      2: begin
        // near miss: cut a reserved word short or run past its end
        k = $urandom_range(0, tcs_pkg::NumKw - 1);
        w = fixed_word(tcs_pkg::KwText[k], tcs_pkg::KwLen[k]);
        if ($urandom_range(0, 1)) w = w.substr(0, $urandom_range(0, w.len() - 2));
        else                      w = {w, rand_from(tail, $urandom_range(1, 3))};
      end
      3: begin
        k = $urandom_range(0, tcs_pkg::NumOp - 1);
        for (int i = 0; i < 8; i++)
          op_text[i] = (i < 4) ? tcs_pkg::OpText[k][i] : tcs_pkg::CharNul;
        w = fixed_word(op_text, tcs_pkg::OpLen[k]);
      end
      4, 5: w = {rand_from(lower, 1), rand_from(tail, $urandom_range(0, 10))};
      6:    w = rand_from("0123456789", $urandom_range(1, 10));
      7:    w = {rand_from("0123456789", $urandom_range(0, 4)), ".",
                 rand_from("0123456789", $urandom_range(0, 4))};
      default: w = rand_from("az_09.+-*/=!<>", $urandom_range(1, 3));
    endcase
    // an error would freeze the block, so it is saved for the closing phase
    if (word_class(w) == tcs_pkg::ClsError) w = rand_from(lower, $urandom_range(1, 4));
    return w;
  endfunction

  task automatic send_separator();
    logic [7:0]  ws [6];
    int unsigned pick;
    ws = '{tcs_pkg::CharTab, 8'h0A, 8'h0B, 8'h0C, tcs_pkg::CharCr, tcs_pkg::CharSpace};
    pick = $urandom_range(0, 99);
    if (pick < 30)      send_char(tcs_pkg::CharSemi, 1'b0);
    else if (pick < 85) send_char(ws[$urandom_range(0, 5)], 1'b0);
    else                send_char(8'($urandom_range(0, 255)), 1'b1);
    random_items_sent++;
  endtask

  // ------------------------------------------------------------------
  // Output side: stall pattern switches between calm, light, periodic
  // and heavy modes.
  // ------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= (cycle_count % 3 == 0);
      default: out_stall_i <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Result checker: every taken transaction must match the oldest expectation.
  always @(posedge clk_i) begin
    tcs_pkg::scan_out_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result class %0d last %0b",
                                  out_data_o.token_class, out_data_o.last));
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.token_class != exp_res.token_class)
          report_mismatch($sformatf("token_class %0d, expected %0d",
                                    out_data_o.token_class, exp_res.token_class));
        if (out_data_o.last != exp_res.last)
          report_mismatch($sformatf("last %0b, expected %0b",
                                    out_data_o.last, exp_res.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout, %0d results outstanding", expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin
    string w;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    scan_st.stuck = 1'b0;
    scan_st = cleared_token(scan_st);

    // Opening rows: separators on an empty token, end-of-stream with both
    // char extremes (ignored), and tokens of every class but the error class.
    add_row(opening_rows, tcs_pkg::CharSemi, 1'b0, 1,
            tcs_pkg::ClsLineBreak, tcs_pkg::ClsLineBreak);
    add_row(opening_rows, 8'hFF, 1'b1, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_row(opening_rows, tcs_pkg::CharTab, 1'b0, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "void");
    add_row(opening_rows, 8'h0A, 1'b0, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "<=");
    add_row(opening_rows, tcs_pkg::CharSemi, 1'b0, -1,
            tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, ".");     // lone dot is a float
    add_row(opening_rows, 8'h0B, 1'b0, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "90");
    add_row(opening_rows, 8'h0C, 1'b0, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "_z9");
    add_row(opening_rows, tcs_pkg::CharNul, 1'b1, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "0.");
    add_row(opening_rows, tcs_pkg::CharSpace, 1'b0, -1,
            tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(opening_rows, "a");
    add_row(opening_rows, tcs_pkg::CharCr, 1'b0, -1, tcs_pkg::ClsError, tcs_pkg::ClsError);

    // Closing rows: high byte in a token gives an error, the ';' after it
    // yields no line break, then everything is ignored.
    add_row(closing_rows, "x", 1'b0, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_row(closing_rows, 8'hC3, 1'b0, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_row(closing_rows, tcs_pkg::CharSemi, 1'b0, 1, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_row(closing_rows, tcs_pkg::CharNul, 1'b1, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_row(closing_rows, tcs_pkg::CharSemi, 1'b0, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);
    add_word_rows(closing_rows, "int");
    add_row(closing_rows, tcs_pkg::CharSpace, 1'b0, 0, tcs_pkg::ClsError, tcs_pkg::ClsError);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_rows(opening_rows);

    // Random part: well-formed tokens, sometimes back-to-back separators.
    while (random_items_sent < RandomItems) begin
      if ($urandom_range(0, 99) < 85) begin
        w = random_token();
        for (int i = 0; i < w.len(); i++) send_char(w[i], 1'b0);
        random_items_sent += w.len();
      end
      send_separator();
      // hold the input once midway until the output side has caught up
      if (!held_once && random_items_sent >= RandomItems / 2) begin
        held_once = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_results.size() != 0);
        burst_left = 0;
      end
    end

    send_rows(closing_rows);
    // noise after the error latched: must produce nothing
    for (int i = 0; i < 40; i++)
      send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
